>>> hdl/ftam_pkg.sv
// Package: types, codes and defaults for the federate time-advance manager.
package ftam_pkg;

	localparam int TIME_WIDTH_DEF = 64;
	localparam int GEN_WIDTH_DEF  = 64;
	localparam int LA_W           = 63;

	typedef enum logic [3:0] {
		OP_ADV_REQ      = 4'd0,
		OP_GRANT        = 4'd1,
		OP_FLUSH_GRANT  = 4'd2,
		OP_REG_REQ      = 4'd3,
		OP_REG_GRANT    = 4'd4,
		OP_REG_OFF      = 4'd5,
		OP_MODIFY_LA    = 4'd6,
		OP_CON_REQ      = 4'd7,
		OP_CON_GRANT    = 4'd8,
		OP_CON_OFF      = 4'd9,
		OP_ASYNC_ON     = 4'd10,
		OP_ASYNC_OFF    = 4'd11,
		OP_DEACTIVATE   = 4'd12,
		OP_START        = 4'd13,
		OP_RSVD14       = 4'd14,
		OP_RSVD15       = 4'd15
	} op_t;

	typedef enum logic [3:0] {
		ST_APPLIED      = 4'd0,
		ST_INACTIVE     = 4'd1,
		ST_INVALID_TIME = 4'd2,
		ST_ADV_PENDING  = 4'd3,
		ST_REG_PENDING  = 4'd4,
		ST_CON_PENDING  = 4'd5,
		ST_PASSED       = 4'd6,
		ST_EXHAUSTED    = 4'd7,
		ST_REQ_PENDING  = 4'd8,
		ST_ALREADY_EN   = 4'd9,
		ST_NOT_EN       = 4'd10,
		ST_ALREADY_DIS  = 4'd11,
		ST_INVALID_LA   = 4'd12,
		ST_REJECTED     = 4'd13
	} status_t;

	localparam logic [2:0] MODE_NMR   = 3'd1;
	localparam logic [2:0] MODE_NMRA  = 3'd3;
	localparam logic [2:0] MODE_FLUSH = 3'd4;
	localparam logic [2:0] PEND_NONE  = 3'd0;
	localparam logic [2:0] PEND_FLUSH = 3'd5;

	typedef struct packed {
		logic [3:0]        operation;
		logic [2:0]        advance_mode;
		logic signed [63:0] time_primary;
		logic signed [63:0] time_secondary;
		logic              secondary_present;
		logic [62:0]       interval_value;
		logic [63:0]       generation_tag;
	} req_t;

	typedef struct packed {
		logic [3:0]         status;
		logic [63:0]        generation_out;
		logic signed [63:0] current_time_out;
		logic               active_out;
		logic               regulating_out;
		logic               constrained_out;
		logic               async_out;
		logic               advance_pending_out;
		logic [2:0]         pending_mode_out;
		logic               exclusive_out;
		logic               receive_allowed_out;
		logic [62:0]        lookahead_out;
	} rsp_t;

endpackage

>>> hdl/ftam_core.sv
// Module: federate time state and the per-event update logic.
module ftam_core
	import ftam_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF,
	parameter int GEN_WIDTH  = GEN_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req,
	output rsp_t rsp
);

	typedef logic signed [TIME_WIDTH-1:0] tm_t;
	typedef logic [GEN_WIDTH-1:0]         gn_t;
	localparam gn_t GMAX = '1;

	logic        act_q, tv_q, ov_q, lv_q, lrv_q, sv_q;
	tm_t         now_q, tgt_q, bnd_q, opt_q;
	logic [LA_W-1:0] la_q, lareq_q, shr_q;
	logic [2:0]  mode_q;
	gn_t         agen_q, rgen_q, cgen_q, ctr_q;
	logic        freg_q, fcon_q, fasy_q, fexc_q;

	logic        act_d, tv_d, ov_d, lv_d, lrv_d, sv_d;
	tm_t         now_d, tgt_d, bnd_d, opt_d;
	logic [LA_W-1:0] la_d, lareq_d, shr_d;
	logic [2:0]  mode_d;
	gn_t         agen_d, rgen_d, cgen_d, ctr_d;
	logic        freg_d, fcon_d, fasy_d, fexc_d;
	status_t     st;
	gn_t         gen;

	tm_t tp, ts, eff, gtime;
	gn_t tag;
	logic [LA_W-1:0] iv, remain, la_g;
	logic [63:0] elapsed_x;
	logic tag_adv_ok, flush_ok;

	assign tp  = req.time_primary[TIME_WIDTH-1:0];
	assign ts  = req.time_secondary[TIME_WIDTH-1:0];
	assign tag = req.generation_tag[GEN_WIDTH-1:0];
	assign iv  = req.interval_value;
	assign eff = ((req.advance_mode == MODE_NMR || req.advance_mode == MODE_NMRA)
		&& req.secondary_present) ? ts : tp;
	assign tag_adv_ok = act_q && tv_q && (tag != '0) && (tag == agen_q);
	// grant time: flush grant lands at time_primary, plain grant at the target
	assign gtime = (op_t'(req.operation) == OP_FLUSH_GRANT) ? tp : tgt_q;
	// 64-bit modular difference of the sign-extended times
	assign elapsed_x = 64'(gtime) - 64'(now_q);
	assign remain    = (la_q > shr_q) ? la_q - shr_q : '0;
	assign flush_ok  = tag_adv_ok && mode_q == PEND_FLUSH && req.secondary_present
		&& !(tp < now_q) && !(bnd_q < tp) && !(ts < tp) && !(bnd_q < ts);

	always_comb begin
		act_d = act_q; tv_d = tv_q; ov_d = ov_q; lv_d = lv_q; lrv_d = lrv_q;
		sv_d = sv_q; now_d = now_q; tgt_d = tgt_q; bnd_d = bnd_q; opt_d = opt_q;
		la_d = la_q; lareq_d = lareq_q; shr_d = shr_q; mode_d = mode_q;
		agen_d = agen_q; rgen_d = rgen_q; cgen_d = cgen_q; ctr_d = ctr_q;
		freg_d = freg_q; fcon_d = fcon_q; fasy_d = fasy_q; fexc_d = fexc_q;
		st = ST_APPLIED; gen = '0; la_g = la_q;
		if (sv_q && lv_q) begin
			la_g = (elapsed_x >= {1'b0, remain}) ? shr_q : la_q - elapsed_x[LA_W-1:0];
		end
		unique case (op_t'(req.operation))
			OP_ADV_REQ: begin
				if (!act_q) st = ST_INACTIVE;
				else if (req.advance_mode > MODE_FLUSH) st = ST_INVALID_TIME;
				else if (tv_q) st = ST_ADV_PENDING;
				else if (lrv_q) st = ST_REG_PENDING;
				else if (cgen_q != '0) st = ST_CON_PENDING;
				else if (tp < now_q) st = ST_PASSED;
				else if (ov_q && tp < opt_q) st = ST_PASSED;
				else if (eff < now_q || tp < eff) st = ST_INVALID_TIME;
				else if (ctr_q == GMAX) st = ST_EXHAUSTED;
				else begin
					if (freg_q && lv_q && la_q == '0 && now_q < tp) fexc_d = 1'b1;
					agen_d = ctr_q; ctr_d = ctr_q + 1'b1; gen = ctr_q;
					tgt_d = eff; tv_d = 1'b1; bnd_d = tp;
					mode_d = req.advance_mode + 3'd1;
				end
			end
			OP_GRANT, OP_FLUSH_GRANT: begin
				if ((op_t'(req.operation) == OP_GRANT) ? !tag_adv_ok : !flush_ok)
					st = (op_t'(req.operation) == OP_GRANT) ? ST_REJECTED : ST_INVALID_TIME;
				else begin
					la_d = la_g;
					if (sv_q && lv_q && elapsed_x >= {1'b0, remain}) begin
						sv_d = 1'b0; shr_d = '0;
					end
					now_d = gtime; tv_d = 1'b0; tgt_d = '0; bnd_d = '0;
					mode_d = PEND_NONE; agen_d = '0; gen = tag;
					if (op_t'(req.operation) == OP_GRANT) begin
						if (ov_q && !(gtime < opt_q)) begin ov_d = 1'b0; opt_d = '0; end
					end else if (!(tp < ts)) begin
						ov_d = 1'b0; opt_d = '0;
					end else begin
						ov_d = 1'b1; opt_d = ts;
					end
				end
			end
			OP_REG_REQ: begin
				if (!act_q) st = ST_INACTIVE;
				else if (tv_q) st = ST_ADV_PENDING;
				else if (lrv_q) st = ST_REQ_PENDING;
				else if (freg_q) st = ST_ALREADY_EN;
				else if (ctr_q == GMAX) st = ST_EXHAUSTED;
				else begin
					rgen_d = ctr_q; ctr_d = ctr_q + 1'b1; gen = ctr_q;
					lareq_d = iv; lrv_d = 1'b1;
				end
			end
			OP_REG_GRANT: begin
				if (!act_q || !lrv_q || tag == '0 || tag != rgen_q) st = ST_REJECTED;
				else begin
					freg_d = 1'b1; fexc_d = 1'b0; la_d = lareq_q; lv_d = 1'b1;
					lareq_d = '0; lrv_d = 1'b0; shr_d = '0; sv_d = 1'b0;
					rgen_d = '0; gen = tag;
				end
			end
			OP_REG_OFF: begin
				if (!act_q) st = ST_INACTIVE;
				else if (!freg_q) st = ST_NOT_EN;
				else begin
					freg_d = 1'b0; fexc_d = 1'b0; la_d = '0; lv_d = 1'b0;
					shr_d = '0; sv_d = 1'b0;
				end
			end
			OP_MODIFY_LA: begin
				if (!act_q) st = ST_INACTIVE;
				else if (tv_q) st = ST_ADV_PENDING;
				else if (!freg_q || !lv_q) st = ST_NOT_EN;
				else if (iv >= la_q) begin
					la_d = iv; shr_d = '0; sv_d = 1'b0;
				end else begin
					shr_d = iv; sv_d = 1'b1;
				end
			end
			OP_CON_REQ: begin
				if (!act_q) st = ST_INACTIVE;
				else if (tv_q) st = ST_ADV_PENDING;
				else if (cgen_q != '0) st = ST_REQ_PENDING;
				else if (fcon_q) st = ST_ALREADY_EN;
				else if (ctr_q == GMAX) st = ST_EXHAUSTED;
				else begin
					cgen_d = ctr_q; ctr_d = ctr_q + 1'b1; gen = ctr_q;
				end
			end
			OP_CON_GRANT: begin
				if (!act_q || cgen_q == '0 || tag != cgen_q) st = ST_REJECTED;
				else begin
					fcon_d = 1'b1; cgen_d = '0; gen = tag;
				end
			end
			OP_CON_OFF: begin
				if (!act_q) st = ST_INACTIVE;
				else if (!fcon_q) st = ST_NOT_EN;
				else fcon_d = 1'b0;
			end
			OP_ASYNC_ON: begin
				if (!act_q) st = ST_INACTIVE;
				else if (fasy_q) st = ST_ALREADY_EN;
				else fasy_d = 1'b1;
			end
			OP_ASYNC_OFF: begin
				if (!act_q) st = ST_INACTIVE;
				else if (!fasy_q) st = ST_ALREADY_DIS;
				else fasy_d = 1'b0;
			end
			OP_DEACTIVATE: begin
				act_d = 1'b0; tv_d = 1'b0; ov_d = 1'b0; lv_d = 1'b0; lrv_d = 1'b0;
				sv_d = 1'b0; now_d = '0; tgt_d = '0; bnd_d = '0; opt_d = '0;
				la_d = '0; lareq_d = '0; shr_d = '0; mode_d = PEND_NONE;
				agen_d = '0; rgen_d = '0; cgen_d = '0;
				freg_d = 1'b0; fcon_d = 1'b0; fasy_d = 1'b0; fexc_d = 1'b0;
			end
			OP_START: begin
				if (act_q) st = ST_ALREADY_EN;
				else begin
					act_d = 1'b1; now_d = tp;
				end
			end
			default: st = ST_REJECTED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0; tv_q <= 1'b0; ov_q <= 1'b0; lv_q <= 1'b0; lrv_q <= 1'b0;
			sv_q <= 1'b0; now_q <= '0; tgt_q <= '0; bnd_q <= '0; opt_q <= '0;
			la_q <= '0; lareq_q <= '0; shr_q <= '0; mode_q <= PEND_NONE;
			agen_q <= '0; rgen_q <= '0; cgen_q <= '0; ctr_q <= gn_t'(1);
			freg_q <= 1'b0; fcon_q <= 1'b0; fasy_q <= 1'b0; fexc_q <= 1'b0;
		end else if (fire) begin
			act_q <= act_d; tv_q <= tv_d; ov_q <= ov_d; lv_q <= lv_d; lrv_q <= lrv_d;
			sv_q <= sv_d; now_q <= now_d; tgt_q <= tgt_d; bnd_q <= bnd_d; opt_q <= opt_d;
			la_q <= la_d; lareq_q <= lareq_d; shr_q <= shr_d; mode_q <= mode_d;
			agen_q <= agen_d; rgen_q <= rgen_d; cgen_q <= cgen_d; ctr_q <= ctr_d;
			freg_q <= freg_d; fcon_q <= fcon_d; fasy_q <= fasy_d; fexc_q <= fexc_d;
		end
	end

	always_comb begin
		rsp.status              = st;
		rsp.generation_out      = 64'(gen);
		rsp.current_time_out    = 64'(now_d);
		rsp.active_out          = act_d;
		rsp.regulating_out      = freg_d;
		rsp.constrained_out     = fcon_d;
		rsp.async_out           = fasy_d;
		rsp.advance_pending_out = tv_d;
		rsp.pending_mode_out    = mode_d;
		rsp.exclusive_out       = fexc_d;
		rsp.receive_allowed_out = act_d && (!fcon_d || fasy_d || tv_d);
		rsp.lookahead_out       = (freg_d && lv_d) ? la_d : '0;
	end

`ifndef SYNTHESIS
	a_tv_mode: assert property (@(posedge clk) disable iff (!arst_n)
		tv_q == (mode_q != PEND_NONE)) else $error("pending flag and mode disagree");
	a_ctr_nz: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_q != '0) else $error("generation counter wrapped to zero");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!act_q |-> (!tv_q && !freg_q && !fcon_q)) else $error("state set while inactive");
`endif

endmodule

>>> hdl/federate_time_advance_manager.sv
// Top level: request/result registers around the federate time-advance core.
//
// One request channel (in_*) and one result channel (out_*), both valid/stall.
// Every request gives exactly one result. A request is taken at an edge
// with in_valid high and in_stall low; at that edge it updates the federate
// state and its result is registered into the output register, or into
// the skid slot while the receiver stalls. The block takes one request
// per cycle while in_stall is low.
// A two-entry skid buffer sits on the output side: while the receiver
// stalls, one more request can still be accepted, then in_stall rises and
// holds until the receiver drains a result. A stalled result never changes.
// Reset (arst_n low, asynchronous) returns the federate to inactive, clears
// all times, lookahead and pending requests, and sets the generation counter
// to one; no result is pending after reset.
module federate_time_advance_manager
	import ftam_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF,
	parameter int GEN_WIDTH  = GEN_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	logic fire;
	rsp_t rsp;
	rsp_t main_q, skid_q;
	logic main_v_q, skid_v_q;

	// stall the source once the skid slot holds a result
	assign in_stall = skid_v_q;
	assign fire     = in_valid && !in_stall;

	ftam_core #(.TIME_WIDTH(TIME_WIDTH), .GEN_WIDTH(GEN_WIDTH)) u_core (
		.clk(clk), .arst_n(arst_n), .fire(fire), .req(in_data), .rsp(rsp)
	);

	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || !out_stall) begin
				// output slot free: refill from skid first, else from the core
				main_v_q <= skid_v_q || fire;
				skid_v_q <= 1'b0;
			end else if (fire) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || !out_stall) begin
			main_q <= skid_v_q ? skid_q : rsp;
		end
		if (main_v_q && out_stall && fire) begin
			skid_q <= rsp;
		end
	end

`ifndef SYNTHESIS
	a_skid_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q) else $error("skid holds a result ahead of output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid) else $error("accepted request produced no result");
`endif

endmodule

>>> sim/ftam_checker.sv
// Checker for the federate time-advance manager: predicts each result and compares it.
module ftam_checker
	import ftam_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  req_t               in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  rsp_t               out_data,
	output int                 fail_count,
	output int                 pending,
	output int                 n_checked,
	output logic               hint_active,
	output logic signed [63:0] hint_now,
	output logic [63:0]        hint_adv_gen,
	output logic [63:0]        hint_reg_gen,
	output logic [63:0]        hint_con_gen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic               active, tgt_valid, opt_valid, la_valid, la_req_valid, shrink_valid;
	logic               reg_en, con_en, asy_en, exc_en;
	logic signed [63:0] now_t, tgt_time, boundary, opt_bound;
	logic [62:0]        la_now, la_req, la_shrink;
	logic [2:0]         mode_pend;
	logic [63:0]        adv_gen, reg_gen, con_gen, gen_ctr;
	rsp_t               awaited_results[$];

	task automatic clear_federate();
		active = 0; tgt_valid = 0; opt_valid = 0; la_valid = 0; la_req_valid = 0;
		shrink_valid = 0; reg_en = 0; con_en = 0; asy_en = 0; exc_en = 0;
		now_t = 0; tgt_time = 0; boundary = 0; opt_bound = 0;
		la_now = 0; la_req = 0; la_shrink = 0;
		mode_pend = PEND_NONE; adv_gen = 0; reg_gen = 0; con_gen = 0;
	endtask

	task automatic grant_advance(input logic [63:0] tag, output bit ok);
		logic [63:0] elapsed, remaining;
		ok = 0;
		if (!active || !tgt_valid || tag == 0 || tag != adv_gen)
			return;
		// shrink a reduced lookahead by the time that passes
		if (shrink_valid && la_valid) begin
			elapsed   = tgt_time - now_t;
			remaining = (la_now > la_shrink) ? {1'b0, la_now - la_shrink} : 64'd0;
			if (elapsed >= remaining) begin
				la_now = la_shrink; shrink_valid = 0; la_shrink = 0;
			end else
				la_now = la_now - elapsed[62:0];
		end
		now_t = tgt_time; tgt_valid = 0; tgt_time = 0;
		if (opt_valid && !(now_t < opt_bound)) begin
			opt_valid = 0; opt_bound = 0;
		end
		boundary = 0; mode_pend = PEND_NONE; adv_gen = 0;
		ok = 1;
	endtask

	task automatic apply_event(input req_t r, output rsp_t e);
		status_t            st;
		logic [63:0]        gen;
		logic signed [63:0] tp, ts, eff;
		logic [2:0]         m;
		bit                 ok;
		st = ST_APPLIED; gen = 0;
		tp = r.time_primary; ts = r.time_secondary; m = r.advance_mode;
		case (r.operation)
		OP_ADV_REQ: begin
			eff = ((m == MODE_NMR || m == MODE_NMRA) && r.secondary_present) ? ts : tp;
			if (!active) st = ST_INACTIVE;
			else if (m > MODE_FLUSH) st = ST_INVALID_TIME;
			else if (tgt_valid) st = ST_ADV_PENDING;
			else if (la_req_valid) st = ST_REG_PENDING;
			else if (con_gen != 0) st = ST_CON_PENDING;
			else if (tp < now_t) st = ST_PASSED;
			else if (opt_valid && tp < opt_bound) st = ST_PASSED;
			else if (eff < now_t || tp < eff) st = ST_INVALID_TIME;
			else if (gen_ctr == '1) st = ST_EXHAUSTED;
			else begin
				if (reg_en && la_valid && la_now == 0 && now_t < tp) exc_en = 1;
				adv_gen = gen_ctr; gen_ctr++;
				tgt_time = eff; tgt_valid = 1; boundary = tp;
				mode_pend = m + 3'd1; gen = adv_gen;
			end
		end
		OP_GRANT: begin
			grant_advance(r.generation_tag, ok);
			if (ok) gen = r.generation_tag; else st = ST_REJECTED;
		end
		OP_FLUSH_GRANT: begin
			if (!active || !tgt_valid || r.generation_tag == 0 || r.generation_tag != adv_gen
			    || mode_pend != PEND_FLUSH || !r.secondary_present)
				st = ST_INVALID_TIME;
			else if (tp < now_t || boundary < tp || ts < tp || boundary < ts)
				st = ST_INVALID_TIME;
			else begin
				tgt_time = tp;
				grant_advance(r.generation_tag, ok);
				if (!(tp < ts)) begin
					opt_valid = 0; opt_bound = 0;
				end else begin
					opt_valid = 1; opt_bound = ts;
				end
				gen = r.generation_tag;
			end
		end
		OP_REG_REQ: begin
			if (!active) st = ST_INACTIVE;
			else if (tgt_valid) st = ST_ADV_PENDING;
			else if (la_req_valid) st = ST_REQ_PENDING;
			else if (reg_en) st = ST_ALREADY_EN;
			else if (gen_ctr == '1) st = ST_EXHAUSTED;
			else begin
				reg_gen = gen_ctr; gen_ctr++;
				la_req = r.interval_value; la_req_valid = 1; gen = reg_gen;
			end
		end
		OP_REG_GRANT: begin
			if (!active || !la_req_valid || r.generation_tag == 0
			    || r.generation_tag != reg_gen)
				st = ST_REJECTED;
			else begin
				reg_en = 1; exc_en = 0; la_now = la_req; la_valid = 1;
				la_req = 0; la_req_valid = 0; la_shrink = 0; shrink_valid = 0;
				reg_gen = 0; gen = r.generation_tag;
			end
		end
		OP_REG_OFF: begin
			if (!active) st = ST_INACTIVE;
			else if (!reg_en) st = ST_NOT_EN;
			else begin
				reg_en = 0; exc_en = 0; la_now = 0; la_valid = 0;
				la_shrink = 0; shrink_valid = 0;
			end
		end
		OP_MODIFY_LA: begin
			if (!active) st = ST_INACTIVE;
			else if (tgt_valid) st = ST_ADV_PENDING;
			else if (!reg_en || !la_valid) st = ST_NOT_EN;
			else if (r.interval_value >= la_now) begin
				la_now = r.interval_value; la_shrink = 0; shrink_valid = 0;
			end else begin
				la_shrink = r.interval_value; shrink_valid = 1;
			end
		end
		OP_CON_REQ: begin
			if (!active) st = ST_INACTIVE;
			else if (tgt_valid) st = ST_ADV_PENDING;
			else if (con_gen != 0) st = ST_REQ_PENDING;
			else if (con_en) st = ST_ALREADY_EN;
			else if (gen_ctr == '1) st = ST_EXHAUSTED;
			else begin
				con_gen = gen_ctr; gen_ctr++; gen = con_gen;
			end
		end
		OP_CON_GRANT: begin
			if (!active || con_gen == 0 || r.generation_tag == 0
			    || r.generation_tag != con_gen)
				st = ST_REJECTED;
			else begin
				con_en = 1; con_gen = 0; gen = r.generation_tag;
			end
		end
		OP_CON_OFF: begin
			if (!active) st = ST_INACTIVE;
			else if (!con_en) st = ST_NOT_EN;
			else con_en = 0;
		end
		OP_ASYNC_ON: begin
			if (!active) st = ST_INACTIVE;
			else if (asy_en) st = ST_ALREADY_EN;
			else asy_en = 1;
		end
		OP_ASYNC_OFF: begin
			if (!active) st = ST_INACTIVE;
			else if (!asy_en) st = ST_ALREADY_DIS;
			else asy_en = 0;
		end
		OP_DEACTIVATE: clear_federate();
		OP_START: begin
			if (active) st = ST_ALREADY_EN;
			else begin
				active = 1; now_t = tp;
			end
		end
		default: st = ST_REJECTED;
		endcase

		e.status              = st;
		e.generation_out      = (st == ST_APPLIED) ? gen : 64'd0;
		e.current_time_out    = now_t;
		e.active_out          = active;
		e.regulating_out      = reg_en;
		e.constrained_out     = con_en;
		e.async_out           = asy_en;
		e.advance_pending_out = tgt_valid;
		e.pending_mode_out    = mode_pend;
		e.exclusive_out       = exc_en;
		e.receive_allowed_out = active && (!con_en || asy_en || tgt_valid);
		e.lookahead_out       = (reg_en && la_valid) ? la_now : 63'd0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t w, e;
		if (!arst_n) begin
			clear_federate();
			gen_ctr = 1;
			awaited_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, out_data);
					fail_count++;
				end else begin
					w = awaited_results[0];
					awaited_results.delete(0);
					n_checked++;
					check_field("status", w.status, out_data.status);
					check_field("generation", w.generation_out, out_data.generation_out);
					check_field("time", w.current_time_out, out_data.current_time_out);
					check_field("active", w.active_out, out_data.active_out);
					check_field("regulating", w.regulating_out, out_data.regulating_out);
					check_field("constrained", w.constrained_out, out_data.constrained_out);
					check_field("async", w.async_out, out_data.async_out);
					check_field("adv pending", w.advance_pending_out,
					            out_data.advance_pending_out);
					check_field("pending mode", w.pending_mode_out, out_data.pending_mode_out);
					check_field("exclusive", w.exclusive_out, out_data.exclusive_out);
					check_field("receive allowed", w.receive_allowed_out,
					            out_data.receive_allowed_out);
					check_field("lookahead", w.lookahead_out, out_data.lookahead_out);
				end
			end
			if (in_valid && !in_stall) begin
				apply_event(in_data, e);
				awaited_results.insert(awaited_results.size(), e);
			end
		end
		pending      <= awaited_results.size();
		hint_active  <= active;
		hint_now     <= now_t;
		hint_adv_gen <= adv_gen;
		hint_reg_gen <= reg_gen;
		hint_con_gen <= con_gen;
	end

endmodule

>>> sim/federate_time_advance_manager_test.sv
// Testbench top: drives requests into the federate time-advance manager and gives the verdict.
module federate_time_advance_manager_test
	import ftam_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	req_t               in_data = '0;
	logic               out_valid;
	logic               out_stall = 0;
	rsp_t               out_data;
	int                 fail_count, pending, n_checked;
	logic               hint_active;
	logic signed [63:0] hint_now;
	logic [63:0]        hint_adv_gen, hint_reg_gen, hint_con_gen;

	int send_idle = 0;
	int recv_idle = 0;
	int hold_req  = 0;
	int n_sent    = 0;
	int quiet     = 0;

	localparam logic signed [63:0] T_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] T_MAX = 64'sh7fff_ffff_ffff_ffff;

	initial forever #6 clk = ~clk;

	federate_time_advance_manager DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	ftam_checker monitor (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending(pending), .n_checked(n_checked),
		.hint_active(hint_active), .hint_now(hint_now), .hint_adv_gen(hint_adv_gen),
		.hint_reg_gen(hint_reg_gen), .hint_con_gen(hint_con_gen)
	);

	// Receiver: a long hold-off when asked, otherwise stall at random.
	always @(posedge clk) begin
		int hold_seen, hold_left;
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = 200;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= 5000) begin
				$display("%0t: watchdog expired, %0d results outstanding", $time, pending);
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic req_t make_req(op_t o, logic [2:0] m, logic signed [63:0] tp,
	                                  logic signed [63:0] ts, logic sp, logic [62:0] iv,
	                                  logic [63:0] tag);
		req_t r;
		r.operation = o; r.advance_mode = m; r.time_primary = tp; r.time_secondary = ts;
		r.secondary_present = sp; r.interval_value = iv; r.generation_tag = tag;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Offer one request and hold it until it is taken; idle first at random.
	task automatic issue(input req_t r);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (in_stall);
		n_sent++;
	endtask

	task automatic op(input op_t o, input logic signed [63:0] tp = 0);
		issue(make_req(o, 3'd0, tp, 64'sd0, 1'b0, 63'd0, 64'd0));
	endtask

	// Harmless request between a request and its grant so the hints catch up.
	task automatic filler();
		case ($urandom_range(3))
		0: op(OP_ASYNC_ON);
		1: op(OP_ASYNC_OFF);
		2: issue(make_req(OP_GRANT, 3'd0, 0, 0, 0, 0, rand64()));
		default: op($urandom_range(1) ? OP_RSVD14 : OP_RSVD15);
		endcase
	endtask

	task automatic advance_cycle();
		logic [2:0]         m;
		logic signed [63:0] tp, ts, gp, gs;
		int                 d, a;
		filler();
		m  = ($urandom_range(15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
		d  = $urandom_range(0, 60);
		tp = hint_now + d;
		ts = hint_now + $urandom_range(0, d);
		issue(make_req(OP_ADV_REQ, m, tp, ts, 1'($urandom_range(1)), 63'($urandom), rand64()));
		filler();
		if (m == MODE_FLUSH) begin
			a  = $urandom_range(0, d);
			gp = tp - d + a;
			gs = gp + $urandom_range(0, d - a);
			issue(make_req(OP_FLUSH_GRANT, 3'd0, gp, gs, $urandom_range(7) != 0, 0,
			               hint_adv_gen ^ 64'($urandom_range(7) == 0)));
		end else
			issue(make_req(OP_GRANT, 3'd0, 0, 0, 0, 0,
			               hint_adv_gen ^ 64'($urandom_range(7) == 0)));
	endtask

	// One well-formed sequence with random content, or a noise request.
	task automatic random_sequence();
		logic signed [63:0] st;
		logic [62:0]        iv;
		if (!hint_active && $urandom_range(9) != 0) begin
			case ($urandom_range(9))
			0: st = T_MIN;
			1: st = T_MAX - 200;
			2: st = rand64();
			default: st = $signed(64'($urandom_range(2000))) - 1000;
			endcase
			op(OP_START, st);
		end
		case ($urandom_range(19))
		0, 1, 2, 3, 4, 5, 6, 7: advance_cycle();
		8, 9: begin
			iv = $urandom_range(3) == 0 ? 63'(rand64()) : 63'($urandom_range(0, 100));
			issue(make_req(OP_REG_REQ, 0, 0, 0, 0, iv, 0));
			filler();
			issue(make_req(OP_REG_GRANT, 0, 0, 0, 0, 0, hint_reg_gen));
		end
		10: op(OP_REG_OFF);
		11, 12: issue(make_req(OP_MODIFY_LA, 0, 0, 0, 0, 63'($urandom_range(0, 120)), 0));
		13, 14: begin
			op(OP_CON_REQ);
			filler();
			issue(make_req(OP_CON_GRANT, 0, 0, 0, 0, 0, hint_con_gen));
		end
		15: op(OP_CON_OFF);
		16: op($urandom_range(1) ? OP_ASYNC_ON : OP_ASYNC_OFF);
		17: if ($urandom_range(3) == 0) op(OP_DEACTIVATE); else filler();
		default: issue(make_req(op_t'($urandom_range(15)), 3'($urandom_range(7)), rand64(),
		                        rand64(), 1'($urandom_range(1)), 63'(rand64()),
		                        $urandom_range(1) ? hint_adv_gen : rand64()));
		endcase
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reserved codes, inactive federate, extremes of time and lookahead.
		op(OP_RSVD14);
		op(OP_RSVD15);
		op(OP_ADV_REQ, 5);
		op(OP_START, T_MIN);
		op(OP_START, 0);
		issue(make_req(OP_ADV_REQ, 3'd7, T_MAX, 0, 0, 0, 0));
		op(OP_DEACTIVATE);
		op(OP_START, 0);
		op(OP_ASYNC_OFF);
		op(OP_ADV_REQ, 10);
		issue(make_req(OP_GRANT, 0, 0, 0, 0, 0, 64'd0));
		issue(make_req(OP_GRANT, 0, 0, 0, 0, 0, hint_adv_gen));
		issue(make_req(OP_ADV_REQ, MODE_NMR, 30, 20, 1, 0, 0));
		op(OP_ASYNC_ON);
		issue(make_req(OP_GRANT, 0, 0, 0, 0, 0, hint_adv_gen));
		issue(make_req(OP_ADV_REQ, MODE_FLUSH, 100, 0, 0, 0, 0));
		op(OP_CON_OFF);
		issue(make_req(OP_FLUSH_GRANT, 0, 50, 80, 0, 0, hint_adv_gen));
		issue(make_req(OP_FLUSH_GRANT, 0, 50, 80, 1, 0, hint_adv_gen));
		op(OP_ADV_REQ, 60);
		issue(make_req(OP_REG_REQ, 0, 0, 0, 0, '1, 0));
		op(OP_REG_OFF);
		issue(make_req(OP_REG_GRANT, 0, 0, 0, 0, 0, hint_reg_gen));
		issue(make_req(OP_MODIFY_LA, 0, 0, 0, 0, 63'd5, 0));
		op(OP_DEACTIVATE);
		op(OP_START, T_MAX);

		// Random phases: sender busy / receiver busy, swapped, then full rate behind one long receiver hold.
		for (int phase = 0; phase < 3; phase++) begin
			in_valid <= 1'b0;
			// let the count of outstanding results catch up with the last request
			repeat (2) @(posedge clk);
			wait (pending == 0);
			@(posedge clk);
			send_idle = (phase == 0) ? 37 : (phase == 1) ? 61 : 0;
			recv_idle = (phase == 0) ? 61 : (phase == 1) ? 37 : 0;
			if (phase == 2)
				hold_req++;
			for (int k = n_sent + 330; n_sent < k;)
				random_sequence();
		end

		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		wait (pending == 0);
		repeat (5) @(posedge clk);
		$display("Sent %0d requests over three stall patterns and one long receiver hold;",
		         n_sent);
		$display("checked %0d results with %0d field mismatches.", n_checked, fail_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/ftam_pkg.sv
hdl/ftam_core.sv
hdl/federate_time_advance_manager.sv
sim/ftam_checker.sv
sim/federate_time_advance_manager_test.sv
